/* rtl/core/pfifo_pkg.sv */
`timescale 1ns / 1ps

package pfifo_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    // operation codes carried in the low bits of an input transfer
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

endpackage

/* rtl/core/pfifo_mem.sv */
`timescale 1ns / 1ps

module pfifo_mem #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ID_BITS-1:0]       wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ID_BITS-1:0]       rd_data
);

    logic [ID_BITS-1:0] mem [DEPTH];
    logic [ID_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read: data appears in the cycle after the address
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/pfifo_seq.sv */
`timescale 1ns / 1ps

module pfifo_seq #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request side
    input  logic                       in_valid,
    output logic                       in_ready,
    input  pfifo_pkg::op_t             in_op,
    input  logic [ID_BITS-1:0]         in_id,
    // result side
    output logic                       res_valid,
    input  logic                       res_ready,
    output pfifo_pkg::status_t         res_status,
    output logic [ID_BITS-1:0]         res_id,
    output logic [$clog2(DEPTH+1)-1:0] res_count,
    // memory port
    output logic                       mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
    output logic [ID_BITS-1:0]         mem_wr_data,
    output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
    input  logic [ID_BITS-1:0]         mem_rd_data
);

    import pfifo_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_POP_WAIT = 6'b000100,
        ST_SCAN     = 6'b001000,
        ST_SHIFT    = 6'b010000,
        ST_FIN      = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [PW-1:0]      head_reg, head_next;
    logic [CW-1:0]      occ_reg, occ_next;
    logic [CW-1:0]      k_reg, k_next;
    status_t            status_reg, status_next;
    logic [ID_BITS-1:0] out_id_reg, out_id_next;

    logic [CW-1:0]      k_plus1;
    logic [CW-1:0]      k_plus2;

    // physical slot of the entry at offset off from the head
    function automatic logic [PW-1:0] slot_at(input logic [PW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    assign k_plus1 = k_reg + CW'(1);
    assign k_plus2 = k_reg + CW'(2);

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        head_next   = head_reg;
        occ_next    = occ_reg;
        k_next      = k_reg;
        status_next = status_reg;
        out_id_next = out_id_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = slot_at(head_reg, occ_reg);
        mem_wr_data = id_reg;
        mem_rd_addr = head_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next    = in_op;
                    id_next    = in_id;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                status_next = STAT_DONE;
                out_id_next = '0;
                k_next      = '0;
                unique case (op_reg)
                    OP_PUSH: begin
                        if (occ_reg == CW'(DEPTH)) begin
                            status_next = STAT_FULL;
                        end else begin
                            mem_wr_en = 1'b1;
                            occ_next  = occ_reg + CW'(1);
                        end
                        state_next = ST_FIN;
                    end
                    OP_POP: begin
                        if (occ_reg == '0) begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_FIN;
                        end else begin
                            state_next = ST_POP_WAIT;
                        end
                    end
                    OP_REMOVE: begin
                        if (occ_reg == '0) begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_FIN;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_POP_WAIT: begin
                out_id_next = mem_rd_data;
                head_next   = slot_at(head_reg, CW'(1));
                occ_next    = occ_reg - CW'(1);
                state_next  = ST_FIN;
            end
            ST_SCAN: begin
                // read data is entry k, fetch entry k+1 behind it
                mem_rd_addr = slot_at(head_reg, k_plus1);
                if (mem_rd_data == id_reg) begin
                    out_id_next = id_reg;
                    if (k_plus1 == occ_reg) begin
                        occ_next   = occ_reg - CW'(1);
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_SHIFT;
                    end
                end else if (k_plus1 == occ_reg) begin
                    status_next = STAT_MISSING;
                    state_next  = ST_FIN;
                end else begin
                    k_next = k_plus1;
                end
            end
            ST_SHIFT: begin
                // read data is entry k+1, moved down into slot k
                mem_wr_en   = 1'b1;
                mem_wr_addr = slot_at(head_reg, k_reg);
                mem_wr_data = mem_rd_data;
                mem_rd_addr = slot_at(head_reg, k_plus2);
                if (k_plus2 < occ_reg) begin
                    k_next = k_plus1;
                end else begin
                    occ_next   = occ_reg - CW'(1);
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        k_reg      <= k_next;
        status_reg <= status_next;
        out_id_reg <= out_id_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_FIN);
    assign res_status = status_reg;
    assign res_id     = out_id_reg;
    assign res_count  = occ_reg;

endmodule

/* rtl/core/process_fifo_with_remove_by_id_core.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                   data
// s_axis    in         s_axis_tvalid/s_axis_tready operation, proc_id
// m_axis    out        m_axis_tvalid/m_axis_tready status, out_id, count_after
//
// push and the unused code pass from dispatch straight to the result; a non-empty pop adds a memory read wait
// remove scans entries from the head until the match, then shifts each entry behind it down one slot;
// a miss scans all entries; the single read port of the slot memory moves one entry a cycle
// reset clears head pointer, count and handshake state; slot contents are not cleared
// a new request is taken while the previous result waits in the output register;
// the sequencer holds its result until that register is free

module process_fifo_with_remove_by_id_core #(
    parameter int DEPTH   = pfifo_pkg::DEPTH_DEF,
    parameter int ID_BITS = pfifo_pkg::ID_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                             s_axis_tvalid,
    output logic                                             s_axis_tready,
    // operation, proc_id
    input  logic [((ID_BITS+2+7)/8)*8-1:0]                   s_axis_tdata,

    output logic                                             m_axis_tvalid,
    input  logic                                             m_axis_tready,
    // status, out_id, count_after
    output logic [((ID_BITS+2+$clog2(DEPTH+1)+7)/8)*8-1:0]  m_axis_tdata
);

    import pfifo_pkg::*;

    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((ID_BITS + 2 + CW + 7) / 8) * 8;

    op_t                in_op;
    logic [ID_BITS-1:0] in_id;

    logic               res_valid;
    logic               res_ready;
    status_t            res_status;
    logic [ID_BITS-1:0] res_id;
    logic [CW-1:0]      res_count;

    logic               mem_wr_en;
    logic [PW-1:0]      mem_wr_addr;
    logic [ID_BITS-1:0] mem_wr_data;
    logic [PW-1:0]      mem_rd_addr;
    logic [ID_BITS-1:0] mem_rd_data;

    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    // unpack the input transfer, padding bits ignored
    assign in_op = op_t'(s_axis_tdata[1:0]);
    assign in_id = s_axis_tdata[ID_BITS+1:2];

    pfifo_seq #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (in_op),
        .in_id       (in_id),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_status  (res_status),
        .res_id      (res_id),
        .res_count   (res_count),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    pfifo_mem #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_W'({res_count, res_id, res_status});
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
